@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and held off during reset
`define SMLI_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, clocked on clk and held off during reset
`define SMLI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/smli_pkg.sv @@
// ----------------------------------------------------------------------------
// smli_pkg
// types and constants of the sorted map linear interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package smli_pkg;

	localparam int GRP_W  = 5;
	localparam int POS_W  = 31;
	localparam int VAL_W  = 26;
	localparam int PROD_W = POS_W + VAL_W;
	localparam int QCNT_W = 5;
	localparam int BLK    = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic             operation;
		logic [GRP_W-1:0] group_id;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic [GRP_W-1:0] grp;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic shift;
		logic ovw;
	} ctl_t;

	typedef struct packed {
		logic less;
		logic le;
		logic gt;
	} flags_t;

	typedef struct packed {
		logic eq;
		logic b;
		logic a;
	} sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMP,
		S_INS,
		S_SEL1,
		S_SEL2,
		S_PREP,
		S_MUL,
		S_LOAD,
		S_DIV
	} state_t;

endpackage

`default_nettype wire

@@ rtl/smli_cell.sv @@
// ----------------------------------------------------------------------------
// smli_cell
// one breakpoint slot of the sorted chain: compare, shift and select flags
// ----------------------------------------------------------------------------
`default_nettype none

module smli_cell
	import smli_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire ctl_t   ctl,
	input  wire entry_t key,
	input  wire logic   valid,
	input  wire entry_t prev_entry,
	input  wire logic   prev_less,
	input  wire logic   prev_gt,
	input  wire logic   next_le,
	output entry_t      entry,
	output flags_t      flags,
	output sel_t        sel
);

	entry_t entry_q;
	sel_t   sel_q;
	logic   grp_eq;
	logic   eq;

	always_comb begin
		grp_eq      = valid && (entry_q.grp == key.grp);
		eq          = grp_eq && (entry_q.pos == key.pos);
		flags.less  = valid && ((entry_q.grp < key.grp) ||
			(grp_eq && (entry_q.pos < key.pos)));
		flags.le    = grp_eq && (entry_q.pos <= key.pos);
		flags.gt    = grp_eq && (entry_q.pos > key.pos);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && !flags.less) begin
			entry_q <= prev_less ? key : prev_entry;
		end else if (ctl.ovw && eq) begin
			entry_q.val <= key.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (ctl.cmp) begin
			sel_q.eq <= eq;
			sel_q.b  <= flags.le && !next_le;
			sel_q.a  <= flags.gt && !prev_gt;
		end
	end

	assign entry = entry_q;
	assign sel   = sel_q;

endmodule

`default_nettype wire

@@ rtl/smli_div.sv @@
// ----------------------------------------------------------------------------
// smli_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smli_div
	import smli_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] num,
	input  wire logic [POS_W-1:0]  den,
	output logic [VAL_W-1:0]       quot,
	output logic                   done
);

	logic [POS_W-1:0]  rem_q;
	logic [VAL_W-1:0]  nq_q;
	logic [VAL_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [POS_W:0]    trial;
	logic [POS_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, nq_q[VAL_W-1]};
		diff  = trial - {1'b0, den};
		ge    = trial >= {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[PROD_W-1:VAL_W];
			nq_q  <= num[VAL_W-1:0];
		end else if (run_q) begin
			rem_q <= ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
			nq_q  <= {nq_q[VAL_W-2:0], 1'b0};
			quo_q <= {quo_q[VAL_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= QCNT_W'(VAL_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/sorted_map_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// sorted_map_linear_interpolator
// sorted breakpoint table with clamped linear interpolation
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; busy stays high
// until the result is out, so one request is in flight at a time.
// the table is a row of cells kept sorted by (group, position); an insert
// shifts every cell above the new key up by one neighbor, all together in the insert state.
// insert: compare, then the insert state, then the done strobe.
// query hitting a clamp or an unknown group: compare, the two select levels and prep.
// interpolating query: compare, a two-level select tree, prep and the
// multiply, then the 26-step restoring divider that runs one quotient bit
// per cycle.
// the result is on result from the cycle that done is high until the next
// result; the receiver cannot stall, and the next request may start in that cycle.
// reset clears the entry count, so the table is empty afterwards; cell
// contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_map_linear_interpolator
	import smli_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int GROUP_COUNT = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      result
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NB = (TABLE_DEPTH + BLK - 1) / BLK;

	state_t         state_q;
	state_t         state_nx;
	req_t           req_q;
	logic [CW-1:0]  count_q;
	ctl_t           ctl;
	entry_t         key;
	logic           grp_ok;
	logic           full;
	logic           eq_any;

	entry_t ent [TABLE_DEPTH];
	flags_t flg [TABLE_DEPTH];
	sel_t   sel [TABLE_DEPTH];

	entry_t         blk_b_s1 [NB];
	entry_t         blk_a_s1 [NB];
	logic [NB-1:0]  hit_b_s1;
	logic [NB-1:0]  hit_a_s1;
	entry_t         blk_b_c [NB];
	entry_t         blk_a_c [NB];
	entry_t         b_s2, a_s2, b_c, a_c;
	logic           hb_s2, ha_s2;

	logic [POS_W-1:0]  dx_q, span_q;
	logic [VAL_W-1:0]  mag_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic              div_start;
	logic [VAL_W-1:0]  quot;
	logic              div_done;

	logic              fin;
	rsp_t              fin_rsp;
	logic              done_q;
	rsp_t              result_q;

	assign key    = '{grp: req_q.group_id, pos: req_q.position, val: req_q.value_in};
	assign grp_ok = {4'd0, req_q.group_id} < 9'(GROUP_COUNT);
	assign full   = count_q == CW'(TABLE_DEPTH);

	// row of cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			smli_cell u_cell (
				.clk, .arst_n, .ctl, .key,
				.valid      (count_q > CW'(i)),
				.prev_entry (key),
				.prev_less  (1'b1),
				.prev_gt    (1'b0),
				.next_le    ((TABLE_DEPTH > 1) ? flg[(i + 1) % TABLE_DEPTH].le : 1'b0),
				.entry      (ent[i]),
				.flags      (flg[i]),
				.sel        (sel[i])
			);
		end else if (i == TABLE_DEPTH - 1) begin : g_last
			smli_cell u_cell (
				.clk, .arst_n, .ctl, .key,
				.valid      (count_q > CW'(i)),
				.prev_entry (ent[i-1]),
				.prev_less  (flg[i-1].less),
				.prev_gt    (flg[i-1].gt),
				.next_le    (1'b0),
				.entry      (ent[i]),
				.flags      (flg[i]),
				.sel        (sel[i])
			);
		end else begin : g_mid
			smli_cell u_cell (
				.clk, .arst_n, .ctl, .key,
				.valid      (count_q > CW'(i)),
				.prev_entry (ent[i-1]),
				.prev_less  (flg[i-1].less),
				.prev_gt    (flg[i-1].gt),
				.next_le    (flg[i+1].le),
				.entry      (ent[i]),
				.flags      (flg[i]),
				.sel        (sel[i])
			);
		end
	end

	always_comb begin
		eq_any = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			eq_any = eq_any | sel[i].eq;
		end
	end

	// select tree, first level per block of cells
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			blk_b_c[k] = '0;
			blk_a_c[k] = '0;
			for (int j = 0; j < BLK; j++) begin
				if (k * BLK + j < TABLE_DEPTH) begin
					blk_b_c[k] = blk_b_c[k] | (sel[k*BLK+j].b ? ent[k*BLK+j] : '0);
					blk_a_c[k] = blk_a_c[k] | (sel[k*BLK+j].a ? ent[k*BLK+j] : '0);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL1) begin
			for (int k = 0; k < NB; k++) begin
				blk_b_s1[k] <= blk_b_c[k];
				blk_a_s1[k] <= blk_a_c[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_b_s1 <= '0;
			hit_a_s1 <= '0;
		end else if (state_q == S_SEL1) begin
			for (int k = 0; k < NB; k++) begin
				hit_b_s1[k] <= 1'b0;
				hit_a_s1[k] <= 1'b0;
				for (int j = 0; j < BLK; j++) begin
					if (k * BLK + j < TABLE_DEPTH) begin
						if (sel[k*BLK+j].b) hit_b_s1[k] <= 1'b1;
						if (sel[k*BLK+j].a) hit_a_s1[k] <= 1'b1;
					end
				end
			end
		end
	end

	// second level across blocks
	always_comb begin
		b_c = '0;
		a_c = '0;
		for (int k = 0; k < NB; k++) begin
			b_c = b_c | blk_b_s1[k];
			a_c = a_c | blk_a_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEL2) begin
			b_s2 <= b_c;
			a_s2 <= a_c;
		end
		if (state_q == S_PREP) begin
			dx_q   <= req_q.position - b_s2.pos;
			span_q <= a_s2.pos - b_s2.pos;
			neg_q  <= a_s2.val < b_s2.val;
			mag_q  <= (a_s2.val < b_s2.val) ? b_s2.val - a_s2.val : a_s2.val - b_s2.val;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(dx_q) * PROD_W'(mag_q);
		end
		if (start && !busy) begin
			req_q <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_s2 <= 1'b0;
			ha_s2 <= 1'b0;
		end else if (state_q == S_SEL2) begin
			hb_s2 <= |hit_b_s1;
			ha_s2 <= |hit_a_s1;
		end
	end

	assign div_start = state_q == S_LOAD;

	smli_div u_div (
		.clk, .arst_n,
		.start (div_start),
		.num   (prod_q),
		.den   (span_q),
		.quot,
		.done  (div_done)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_nx = S_CMP;
			S_CMP:  state_nx = (req_q.operation == OP_INSERT) ? S_INS : S_SEL1;
			S_INS:  state_nx = S_IDLE;
			S_SEL1: state_nx = S_SEL2;
			S_SEL2: state_nx = S_PREP;
			S_PREP: state_nx = (hb_s2 && ha_s2) ? S_MUL : S_IDLE;
			S_MUL:  state_nx = S_LOAD;
			S_LOAD: state_nx = S_DIV;
			S_DIV:  if (div_done) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl         = '0;
		fin         = 1'b0;
		fin_rsp     = '0;
		busy        = state_q != S_IDLE;
		unique case (state_q)
			S_CMP: ctl.cmp = 1'b1;
			S_INS: begin
				fin = 1'b1;
				if (grp_ok) begin
					if (eq_any) begin
						ctl.ovw = 1'b1;
					end else if (full) begin
						fin_rsp.status = ST_FULL;
					end else begin
						ctl.shift = 1'b1;
					end
				end
			end
			S_PREP: begin
				if (!(hb_s2 && ha_s2)) begin
					fin = 1'b1;
					priority if (hb_s2) begin
						fin_rsp.value_out = b_s2.val;
					end else if (ha_s2) begin
						fin_rsp.value_out = a_s2.val;
					end else begin
						fin_rsp.status = ST_UNKNOWN;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					fin = 1'b1;
					fin_rsp.value_out = neg_q ? b_s2.val - quot : b_s2.val + quot;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= fin;
			if (ctl.shift) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= fin_rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ rtl/smli_checker.sv @@
// ----------------------------------------------------------------------------
// smli_checker
// port-level checks of the request and result channels
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module smli_checker
	import smli_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t result
);

	logic status_known;

	assign status_known = (result.status == ST_OK) || (result.status == ST_UNKNOWN) ||
		(result.status == ST_FULL);

	`SMLI_ASSERT_NEXT(a_busy_after_req, start && !busy, busy, "busy not raised after request")
	`SMLI_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
	`SMLI_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`SMLI_ASSERT_SAME(a_status_code, done, status_known, "undefined status code")

endmodule

bind sorted_map_linear_interpolator smli_checker u_smli_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

@@ test/sorted_map_linear_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_map_linear_interpolator_tb
// checks the breakpoint table against an in-bench copy of its behavior:
// inserts, overwrites, full table, clamped and interpolated queries, and
// unknown groups, with bursty requests and random gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_map_linear_interpolator_tb;
	import smli_pkg::*;

	localparam int DEPTH  = 1024;
	localparam int GROUPS = 32;
	localparam int LIMIT  = 600000;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	entry_t bp_model [DEPTH];
	int     bp_count;
	rsp_t   pending_rsp [$];
	int     cycle_count;
	bit     failed;
	int     burst_left;

	sorted_map_linear_interpolator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic key_before(entry_t e, logic [GRP_W-1:0] g, logic [POS_W-1:0] p);
		if (e.grp != g) return e.grp < g;
		return e.pos < p;
	endfunction

	// updates the table copy and returns the expected response
	function automatic rsp_t table_predict(req_t r);
		rsp_t rsp;
		int i, first, last, up;
		logic [63:0] dx, span, mag, quot;
		entry_t b, a;
		rsp = '0;
		rsp.status = ST_OK;
		if (r.operation == OP_INSERT) begin
			if (r.group_id >= GROUPS) return rsp;
			i = 0;
			while (i < bp_count && key_before(bp_model[i], r.group_id, r.position)) i++;
			if (i < bp_count && bp_model[i].grp == r.group_id && bp_model[i].pos == r.position) begin
				bp_model[i].val = r.value_in;
				return rsp;
			end
			if (bp_count >= DEPTH) begin
				rsp.status = ST_FULL;
				return rsp;
			end
			for (int k = bp_count; k > i; k--) bp_model[k] = bp_model[k-1];
			bp_model[i] = '{grp: r.group_id, pos: r.position, val: r.value_in};
			bp_count++;
			return rsp;
		end
		if (r.group_id >= GROUPS) begin
			rsp.status = ST_UNKNOWN;
			return rsp;
		end
		first = 0;
		while (first < bp_count && bp_model[first].grp < r.group_id) first++;
		last = first;
		while (last < bp_count && bp_model[last].grp == r.group_id) last++;
		if (last == first) begin
			rsp.status = ST_UNKNOWN;
			return rsp;
		end
		up = first;
		while (up < last && bp_model[up].pos <= r.position) up++;
		if (up == first) begin
			rsp.value_out = bp_model[first].val;
			return rsp;
		end
		if (up == last) begin
			rsp.value_out = bp_model[last-1].val;
			return rsp;
		end
		b = bp_model[up-1];
		a = bp_model[up];
		dx = 64'(r.position - b.pos);
		span = 64'(a.pos - b.pos);
		if (a.val >= b.val) begin
			mag = 64'(a.val - b.val);
			quot = (dx * mag) / span;
			rsp.value_out = VAL_W'(64'(b.val) + quot);
		end else begin
			mag = 64'(b.val - a.val);
			quot = (dx * mag) / span;
			rsp.value_out = VAL_W'(64'(b.val) - quot);
		end
		return rsp;
	endfunction

	// sends one request, predicts on accept, then maybe opens a gap
	task automatic send_request(logic op, logic [GRP_W-1:0] g, logic [POS_W-1:0] p,
			logic [VAL_W-1:0] v);
		req_t r;
		int gap;
		r = '{operation: op, group_id: g, position: p, value_in: v};
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_rsp.push_back(table_predict(r));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic random_insert();
		int idx;
		if (bp_count > 0 && $urandom_range(0, 9) == 0) begin
			idx = $urandom_range(0, bp_count - 1);
			send_request(OP_INSERT, bp_model[idx].grp, bp_model[idx].pos, VAL_W'($urandom));
		end else begin
			send_request(OP_INSERT, GRP_W'($urandom_range(0, GROUPS - 1)), POS_W'($urandom),
				VAL_W'($urandom));
		end
	endtask

	task automatic random_query();
		int idx;
		logic [POS_W-1:0] p;
		if (bp_count > 0 && $urandom_range(0, 4) != 0) begin
			idx = $urandom_range(0, bp_count - 1);
			case ($urandom_range(0, 2))
				0: p = bp_model[idx].pos + POS_W'($urandom_range(0, 8)) - POS_W'(4);
				1: p = bp_model[idx].pos + POS_W'($urandom_range(0, 1 << 24));
				default: p = bp_model[idx].pos;
			endcase
			send_request(OP_QUERY, bp_model[idx].grp, p, VAL_W'($urandom));
		end else begin
			send_request(OP_QUERY, GRP_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
		end
	endtask

	task automatic test_empty_queries();
		send_request(OP_QUERY, '0, '0, '0);
		send_request(OP_QUERY, '1, POS_MAX, VAL_MAX);
	endtask

	task automatic test_insert_extremes();
		send_request(OP_INSERT, '0, '0, '0);
		send_request(OP_INSERT, '1, POS_MAX, VAL_MAX);
		send_request(OP_INSERT, '0, POS_MAX, VAL_MAX);
		send_request(OP_INSERT, '1, '0, '0);
		send_request(OP_QUERY, '0, POS_MAX >> 1, '0);
		send_request(OP_QUERY, '1, POS_MAX - 1, '0);
		send_request(OP_INSERT, '0, '0, VAL_MAX);
		send_request(OP_QUERY, '0, '0, '0);
	endtask

	task automatic test_interpolation();
		send_request(OP_INSERT, 5'd7, 31'd1000, 26'd100);
		send_request(OP_INSERT, 5'd7, 31'd2000, 26'd50000);
		send_request(OP_INSERT, 5'd7, 31'd3000, 26'd17);
		send_request(OP_INSERT, 5'd7, 31'd4000, 26'd17);
		send_request(OP_QUERY, 5'd7, 31'd999, '0);
		send_request(OP_QUERY, 5'd7, 31'd1000, '0);
		send_request(OP_QUERY, 5'd7, 31'd1333, '0);
		send_request(OP_QUERY, 5'd7, 31'd2777, '0);
		send_request(OP_QUERY, 5'd7, 31'd3500, '0);
		send_request(OP_QUERY, 5'd7, 31'd4000, '0);
		send_request(OP_QUERY, 5'd7, POS_MAX, '0);
		send_request(OP_QUERY, 5'd8, 31'd1500, '0);
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 900; n++) begin
			if ($urandom_range(0, 99) < 72) random_insert();
			else random_query();
		end
	endtask

	task automatic test_full_table();
		while (bp_count < DEPTH) random_insert();
		for (int n = 0; n < 40; n++) begin
			case ($urandom_range(0, 2))
				0: send_request(OP_INSERT, GRP_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
				1: random_insert();
				default: random_query();
			endcase
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result value_out=%0h status=%0d",
					result.value_out, result.status);
				failed <= 1'b1;
			end else begin
				want = pending_rsp.pop_front();
				if (result.value_out !== want.value_out) begin
					$error("value_out expected %0h actual %0h", want.value_out, result.value_out);
					failed <= 1'b1;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.status);
					failed <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		failed = 1'b0;
		cycle_count = 0;
		bp_count = 0;
		burst_left = 4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queries();
		test_insert_extremes();
		test_interpolation();
		test_random_mix();
		test_full_table();
		wait_drained();
		repeat (50) @(posedge clk);
		if (!failed && pending_rsp.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sorted_map_linear_interpolator.f @@
+incdir+rtl
rtl/smli_pkg.sv
rtl/smli_cell.sv
rtl/smli_div.sv
rtl/sorted_map_linear_interpolator.sv
rtl/smli_checker.sv
test/sorted_map_linear_interpolator_tb.sv
